>>> rtl/rv32sx_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the RV32I subset execute core.
// Depends on nothing; every other rtl file refers to it by scoped names.
package rv32sx_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int REG_ADDR_W    = 5;
    localparam int XLEN          = 32;

    localparam logic [XLEN-1:0] START_PC_RESET = 32'h0000_0000;
    localparam logic [XLEN-1:0] IO_BASE_RESET  = 32'h1000_0000;
    localparam logic [XLEN-1:0] EXIT_MAGIC     = 32'h0000_5555;
    localparam logic [XLEN-1:0] UPPER_MASK     = 32'hFFFF_F000;

    // configuration register indexes
    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_IO_BASE  = 1'b1;

    // item kinds
    localparam logic OP_INSTR      = 1'b0;
    localparam logic OP_LOAD_REPLY = 1'b1;

    // opcode bits 6:2
    localparam logic [4:0] OPC_LOAD   = 5'd0;
    localparam logic [4:0] OPC_OP_IMM = 5'd4;
    localparam logic [4:0] OPC_AUIPC  = 5'd5;
    localparam logic [4:0] OPC_STORE  = 5'd8;
    localparam logic [4:0] OPC_LUI    = 5'd13;
    localparam logic [4:0] OPC_BRANCH = 5'd24;
    localparam logic [4:0] OPC_JAL    = 5'd27;

    // funct3 codes
    localparam logic [2:0] F3_ADDI = 3'd0;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    // status codes
    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_AWAIT_LOAD = 3'd1;
    localparam logic [2:0] ST_HALTED     = 3'd2;
    localparam logic [2:0] ST_EXITED     = 3'd3;
    localparam logic [2:0] ST_WRONG_KIND = 3'd4;

    // window offsets
    localparam logic [XLEN-1:0] CONSOLE_OFF = 32'd0;
    localparam logic [XLEN-1:0] EXIT_OFF    = 32'd4;

    typedef enum logic [1:0] {
        RS_RUNNING = 2'd0,
        RS_HALTED  = 2'd1,
        RS_EXITED  = 2'd2
    } run_t;

    typedef struct packed {
        logic            op;
        logic [XLEN-1:0] instr_word;
        logic [7:0]      load_byte;
    } item_t;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            mem_valid;
        logic            mem_write;
        logic [XLEN-1:0] mem_addr;
        logic            mem_size;
        logic [XLEN-1:0] mem_wdata;
        logic            console_valid;
        logic [7:0]      console_char;
        logic [2:0]      status;
    } result_t;

    typedef struct packed {
        logic [XLEN-1:0]       pc;
        run_t                  run;
        logic                  load_pending;
        logic [REG_ADDR_W-1:0] pending_dest;
    } arch_t;

    typedef struct packed {
        logic                  en;
        logic [REG_ADDR_W-1:0] addr;
        logic [XLEN-1:0]       data;
    } wb_t;

endpackage

>>> rtl/rv32sx_regfile.sv
`timescale 1ns / 1ps
// Register file x0..x(REG_COUNT-1): one write port, two registered read ports
// with write-through bypass and per-entry valid bits. Uses rv32sx_pkg.
module rv32sx_regfile #(
    parameter int REG_COUNT = rv32sx_pkg::REG_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [rv32sx_pkg::REG_ADDR_W-1:0]  raddr1,
    input  logic [rv32sx_pkg::REG_ADDR_W-1:0]  raddr2,
    input  rv32sx_pkg::wb_t                    wb,
    output logic [rv32sx_pkg::XLEN-1:0]        rdata1,
    output logic [rv32sx_pkg::XLEN-1:0]        rdata2
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [rv32sx_pkg::REG_ADDR_W:0] COUNT = (rv32sx_pkg::REG_ADDR_W + 1)'(REG_COUNT);

    logic [rv32sx_pkg::XLEN-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]        valid_reg;
    logic [rv32sx_pkg::XLEN-1:0] q1_reg;
    logic [rv32sx_pkg::XLEN-1:0] q2_reg;
    logic [rv32sx_pkg::XLEN-1:0] fwd_data_reg;
    logic                        fwd1_reg;
    logic                        fwd2_reg;
    logic                        zero1_reg;
    logic                        zero2_reg;

    logic             wb_ok;
    logic             rok1;
    logic             rok2;
    logic             hit1;
    logic             hit2;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;

    assign widx = wb.addr[IDX_W-1:0];
    assign idx1 = raddr1[IDX_W-1:0];
    assign idx2 = raddr2[IDX_W-1:0];

    assign wb_ok = wb.en && (wb.addr != '0) && ({1'b0, wb.addr} < COUNT);
    assign rok1  = (raddr1 != '0) && ({1'b0, raddr1} < COUNT);
    assign rok2  = (raddr2 != '0) && ({1'b0, raddr2} < COUNT);
    assign hit1  = wb_ok && (wb.addr == raddr1);
    assign hit2  = wb_ok && (wb.addr == raddr2);

    always_ff @(posedge clk)
    begin
        if (wb_ok)
        begin
            mem[widx] <= wb.data;
        end
        if (rd_en)
        begin
            q1_reg       <= mem[idx1];
            q2_reg       <= mem[idx2];
            fwd_data_reg <= wb.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd1_reg  <= 1'b0;
            fwd2_reg  <= 1'b0;
            zero1_reg <= 1'b1;
            zero2_reg <= 1'b1;
        end
        else
        begin
            if (wb_ok)
            begin
                valid_reg[widx] <= 1'b1;
            end
            if (rd_en)
            begin
                fwd1_reg  <= hit1;
                fwd2_reg  <= hit2;
                zero1_reg <= !hit1 && (!rok1 || !valid_reg[idx1]);
                zero2_reg <= !hit2 && (!rok2 || !valid_reg[idx2]);
            end
        end
    end

    assign rdata1 = zero1_reg ? '0 : (fwd1_reg ? fwd_data_reg : q1_reg);
    assign rdata2 = zero2_reg ? '0 : (fwd2_reg ? fwd_data_reg : q2_reg);

endmodule

>>> rtl/rv32sx_exec.sv
`timescale 1ns / 1ps
// Decode and execute of one word: next architectural state, write-back and
// result fields. Purely combinational; uses rv32sx_pkg.
module rv32sx_exec (
    input  rv32sx_pkg::item_t           item,
    input  rv32sx_pkg::arch_t           arch,
    input  logic [rv32sx_pkg::XLEN-1:0] rs1_data,
    input  logic [rv32sx_pkg::XLEN-1:0] rs2_data,
    input  logic [rv32sx_pkg::XLEN-1:0] io_base,
    output rv32sx_pkg::arch_t           arch_next,
    output rv32sx_pkg::wb_t             wb,
    output rv32sx_pkg::result_t         res
);

    logic [31:0] w;
    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] iimm;
    logic [31:0] simm;
    logic [31:0] bimm;
    logic [31:0] jimm;
    logic [31:0] pc_plus4;
    logic [31:0] st_addr;
    logic [31:0] st_off;
    logic [31:0] st_data;
    logic        st_word;
    logic        in_window;
    logic [31:0] npc;
    logic        halt;

    assign w        = item.instr_word;
    assign opc      = w[6:2];
    assign f3       = w[14:12];
    assign rd       = w[11:7];
    assign iimm     = {{20{w[31]}}, w[31:20]};
    assign simm     = {{20{w[31]}}, w[31:25], w[11:7]};
    assign bimm     = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign jimm     = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign pc_plus4 = arch.pc + 32'd4;
    assign st_addr  = rs1_data + simm;
    assign st_off   = st_addr - io_base;
    assign st_word  = (f3 == rv32sx_pkg::F3_SW);
    assign st_data  = st_word ? rs2_data : {24'd0, rs2_data[7:0]};
    assign in_window = (st_off[31:3] == '0);

    always_comb
    begin
        arch_next = arch;
        wb        = '0;
        res       = '0;
        npc       = pc_plus4;
        halt      = 1'b0;
        res.status = rv32sx_pkg::ST_RUNNING;
        if (arch.run == rv32sx_pkg::RS_HALTED)
        begin
            res.status = rv32sx_pkg::ST_HALTED;
        end
        else if (arch.run == rv32sx_pkg::RS_EXITED)
        begin
            res.status = rv32sx_pkg::ST_EXITED;
        end
        else if (arch.load_pending)
        begin
            if (item.op == rv32sx_pkg::OP_LOAD_REPLY)
            begin
                wb.en  = 1'b1;
                wb.addr = arch.pending_dest;
                wb.data = {{24{item.load_byte[7]}}, item.load_byte};
                arch_next.load_pending = 1'b0;
            end
            else
            begin
                res.status = rv32sx_pkg::ST_WRONG_KIND;
            end
        end
        else if (item.op == rv32sx_pkg::OP_LOAD_REPLY)
        begin
            res.status = rv32sx_pkg::ST_WRONG_KIND;
        end
        else
        begin
            wb.addr = rd;
            case (opc)
                rv32sx_pkg::OPC_LUI:
                begin
                    wb.en   = 1'b1;
                    wb.data = w & rv32sx_pkg::UPPER_MASK;
                end
                rv32sx_pkg::OPC_AUIPC:
                begin
                    wb.en   = 1'b1;
                    wb.data = (w & rv32sx_pkg::UPPER_MASK) + arch.pc;
                end
                rv32sx_pkg::OPC_JAL:
                begin
                    wb.en   = 1'b1;
                    wb.data = pc_plus4;
                    npc     = arch.pc + jimm;
                end
                rv32sx_pkg::OPC_OP_IMM:
                begin
                    if (f3 == rv32sx_pkg::F3_ADDI)
                    begin
                        wb.en   = 1'b1;
                        wb.data = rs1_data + iimm;
                    end
                    else
                    begin
                        halt = 1'b1;
                    end
                end
                rv32sx_pkg::OPC_BRANCH:
                begin
                    if (f3 == rv32sx_pkg::F3_BEQ || f3 == rv32sx_pkg::F3_BNE)
                    begin
                        if ((rs1_data == rs2_data) == (f3 == rv32sx_pkg::F3_BEQ))
                        begin
                            npc = arch.pc + bimm;
                        end
                    end
                    else
                    begin
                        halt = 1'b1;
                    end
                end
                rv32sx_pkg::OPC_LOAD:
                begin
                    if (f3 == rv32sx_pkg::F3_LB)
                    begin
                        res.mem_valid = 1'b1;
                        res.mem_addr  = rs1_data + iimm;
                        arch_next.load_pending = 1'b1;
                        arch_next.pending_dest = rd;
                        res.status = rv32sx_pkg::ST_AWAIT_LOAD;
                    end
                    else
                    begin
                        halt = 1'b1;
                    end
                end
                rv32sx_pkg::OPC_STORE:
                begin
                    if (f3 inside {rv32sx_pkg::F3_SB, rv32sx_pkg::F3_SW})
                    begin
                        if (in_window)
                        begin
                            if (!st_word && st_off == rv32sx_pkg::CONSOLE_OFF)
                            begin
                                res.console_valid = 1'b1;
                                res.console_char  = st_data[7:0];
                            end
                            else if (st_word && st_off == rv32sx_pkg::EXIT_OFF
                                     && st_data == rv32sx_pkg::EXIT_MAGIC)
                            begin
                                arch_next.run = rv32sx_pkg::RS_EXITED;
                                res.status    = rv32sx_pkg::ST_EXITED;
                                npc           = arch.pc;
                            end
                        end
                        else
                        begin
                            res.mem_valid = 1'b1;
                            res.mem_write = 1'b1;
                            res.mem_addr  = st_addr;
                            res.mem_size  = st_word;
                            res.mem_wdata = st_data;
                        end
                    end
                    else
                    begin
                        halt = 1'b1;
                    end
                end
                default:
                begin
                    halt = 1'b1;
                end
            endcase
            if (halt)
            begin
                arch_next.run = rv32sx_pkg::RS_HALTED;
                res.status    = rv32sx_pkg::ST_HALTED;
                npc           = arch.pc;
            end
            arch_next.pc = npc;
        end
        res.next_pc = arch_next.pc;
    end

endmodule

>>> rtl/rv32i_subset_execute_core.sv
`timescale 1ns / 1ps
// Top level of the RV32I subset execute core: input stage, state, result stage.
// Uses rv32sx_pkg, rv32sx_regfile and rv32sx_exec.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_ready    | in_data  (op, instr_word, load_byte)
//  res     | res_valid / res_ready  | res_data (next_pc .. status)
//  cfg     | cfg_write              | cfg_index, cfg_wdata
//
// One word per cycle unless the result stalls; input stage, then result stage.
// Register file read is clocked at acceptance, with bypass from the write port.
// State commits when a word moves from the input stage to the result stage.
// A stalled result holds the input stage; in_ready falls only then.
// Reset: pc = start_pc reset value, registers read as zero, core running.
module rv32i_subset_execute_core #(
    parameter int REG_COUNT = rv32sx_pkg::REG_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rv32sx_pkg::item_t           in_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output rv32sx_pkg::result_t         res_data,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [rv32sx_pkg::XLEN-1:0] cfg_wdata
);

    logic                        s1_valid_reg;
    rv32sx_pkg::item_t           s1_item_reg;
    rv32sx_pkg::arch_t           arch_reg;
    logic [rv32sx_pkg::XLEN-1:0] io_base_reg;
    logic                        res_valid_reg;
    rv32sx_pkg::result_t         res_reg;

    logic                        advance;
    logic                        accept;
    rv32sx_pkg::arch_t           arch_next;
    rv32sx_pkg::wb_t             wb_raw;
    rv32sx_pkg::wb_t             wb;
    rv32sx_pkg::result_t         res_next;
    logic [rv32sx_pkg::XLEN-1:0] rs1_data;
    logic [rv32sx_pkg::XLEN-1:0] rs2_data;

    assign advance  = s1_valid_reg && (!res_valid_reg || res_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        wb    = wb_raw;
        wb.en = wb_raw.en && advance;
    end

    rv32sx_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .raddr1 (in_data.instr_word[19:15]),
        .raddr2 (in_data.instr_word[24:20]),
        .wb     (wb),
        .rdata1 (rs1_data),
        .rdata2 (rs2_data)
    );

    rv32sx_exec u_exec (
        .item      (s1_item_reg),
        .arch      (arch_reg),
        .rs1_data  (rs1_data),
        .rs2_data  (rs2_data),
        .io_base   (io_base_reg),
        .arch_next (arch_next),
        .wb        (wb_raw),
        .res       (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            io_base_reg   <= rv32sx_pkg::IO_BASE_RESET;
            arch_reg.pc           <= rv32sx_pkg::START_PC_RESET;
            arch_reg.run          <= rv32sx_pkg::RS_RUNNING;
            arch_reg.load_pending <= 1'b0;
            arch_reg.pending_dest <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                arch_reg <= arch_next;
            end
            else if (cfg_write && cfg_index == rv32sx_pkg::CFG_START_PC)
            begin
                arch_reg.pc <= cfg_wdata;
            end
            if (cfg_write && cfg_index == rv32sx_pkg::CFG_IO_BASE)
            begin
                io_base_reg <= cfg_wdata;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule
